// ===== rtl/hxb_pkg.sv =====
// Package for the hex text to bytes decoder: sizes, codes, the command
// passed from front to back, result and configuration structs.
// Depends on nothing; every other file imports it.
`default_nettype none

package hxb_pkg;

  // Sizing
  localparam int MAX_TEXT    = 4096;
  localparam int MAX_OUT     = 2048;
  localparam int POS_W       = $clog2(MAX_TEXT + 1);
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 12;
  localparam int CNT_W       = 12;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X_LO = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP = 8'h58;

  // Result kinds
  typedef enum logic [1:0] {
    K_DATA = 2'd0,
    K_DONE = 2'd1,
    K_ERR  = 2'd2
  } kind_t;

  // String phase as seen by the back end
  typedef enum logic [1:0] {
    PH_AWAIT,
    PH_RUN,
    PH_FULL,
    PH_ERR
  } phase_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIM  = 2'd0,
    CFG_EMPTY = 2'd1,
    CFG_CAP   = 2'd2
  } cfg_index_t;

  // One classified character: an optional flushed byte from a held '0',
  // then an optional decoded byte or an error, and string start/end marks
  typedef struct packed {
    logic        sos;
    logic        eos;
    logic        flush_valid;
    logic [7:0]  flush_byte;
    logic        dec_valid;
    logic [7:0]  dec_byte;
    logic        err;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        out_byte;
    logic [CNT_W-1:0]  byte_count;
    logic              last;
  } result_t;

  // Effective settings handed to the back end
  typedef struct packed {
    logic              trim_leading;
    logic              empty_as_null;
    logic [CNT_W-1:0]  capacity;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  // ASCII hex digit to nibble
  function automatic nibble_t hex_nibble(input logic [CHAR_W-1:0] c);
    nibble_t r;
    logic [CHAR_W-1:0] d;
    r = '0;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r.ok = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r.ok = 1'b1;
    end
    r.value = d[3:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hxb_if.sv =====
// Valid/ready channel interfaces for the character input and result output.
// Depends on hxb_pkg for field widths.
`default_nettype none

interface hxb_in_if;
  import hxb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic [LEN_W-1:0]  text_length;

  modport source (output valid, output text_char, output text_length, input ready);
  modport sink   (input valid, input text_char, input text_length, output ready);
endinterface

interface hxb_out_if;
  import hxb_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       out_byte;
  logic [CNT_W-1:0] byte_count;
  logic             last;

  modport source (output valid, output kind, output out_byte, output byte_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input byte_count,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/hxb_front.sv =====
// Front end: takes characters, tracks position, parity, the 0x prefix and the
// high nibble, and pushes one classified command per character.
// Depends on hxb_pkg and hxb_if.
`default_nettype none

module hxb_front
  import hxb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  hxb_in_if.sink    in,
  input  wire logic q_full,
  output logic      push,
  output cmd_t      cmd
);

  logic             awaiting, awaiting_next;
  logic [POS_W-1:0] position, position_next;
  logic             len_odd, len_odd_next;
  logic             prefix, prefix_next;
  logic [3:0]       high, high_next;

  logic [POS_W-1:0] eff_pos;
  logic             eff_odd;
  logic             eff_pre;
  logic [3:0]       h;
  logic             do_flush;
  logic             do_dec;
  nibble_t          nib;

  assign in.ready = !q_full;
  assign push     = in.valid && in.ready;

  // Classify the character on the input
  always_comb begin
    cmd      = '0;
    eff_pos  = awaiting ? '0 : position;
    eff_odd  = awaiting ? in.text_length[0] : len_odd;
    eff_pre  = awaiting ? 1'b0 : prefix;
    h        = awaiting ? 4'h0 : high;
    nib      = hex_nibble(in.text_char);
    do_flush = 1'b0;
    do_dec   = 1'b0;

    cmd.sos       = awaiting;
    awaiting_next = 1'b0;
    position_next = eff_pos;
    len_odd_next  = eff_odd;
    prefix_next   = eff_pre;

    if (in.text_char == CH_NUL) begin
      // end of string: a held '0' still counts as a digit
      cmd.eos       = 1'b1;
      awaiting_next = 1'b1;
      prefix_next   = 1'b0;
      do_flush      = eff_pre;
    end else if (eff_pos < POS_W'(MAX_TEXT)) begin
      position_next = eff_pos + POS_W'(1);
      if (eff_pos == '0 && in.text_length > LEN_W'(2) && in.text_char == CH_ZERO) begin
        prefix_next = 1'b1;
      end else if (eff_pos == POS_W'(1) && eff_pre) begin
        prefix_next = 1'b0;
        if (in.text_char != CH_X_LO && in.text_char != CH_X_UP) begin
          do_flush = 1'b1;
          do_dec   = 1'b1;
        end
      end else begin
        do_dec = 1'b1;
      end
    end

    // held '0' taken as the digit at position zero
    if (do_flush) begin
      if (!eff_odd) begin
        h = 4'h0;
      end else begin
        cmd.flush_valid = 1'b1;
        cmd.flush_byte  = {h, 4'h0};
      end
    end

    // digit at the current position
    if (do_dec) begin
      if (!nib.ok) begin
        cmd.err = 1'b1;
      end else if (eff_pos[0] == eff_odd) begin
        h = nib.value;
      end else begin
        cmd.dec_valid = 1'b1;
        cmd.dec_byte  = {h, nib.value};
      end
    end

    high_next = h;
  end

  // Character tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting <= 1'b1;
      position <= '0;
      len_odd  <= 1'b0;
      prefix   <= 1'b0;
      high     <= 4'h0;
    end else if (push) begin
      awaiting <= awaiting_next;
      position <= position_next;
      len_odd  <= len_odd_next;
      prefix   <= prefix_next;
      high     <= high_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hxb_queue.sv =====
// Short command queue between front and back ends.
// Depends on hxb_pkg for cmd_t and the depth.
`default_nettype none

module hxb_queue
  import hxb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      priority case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

// ===== rtl/hxb_back.sv =====
// Back end: applies trimming, capacity, error and end-of-string handling to
// each command and drives up to two result beats through an output register.
// Depends on hxb_pkg and hxb_if.
`default_nettype none

module hxb_back
  import hxb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic q_valid,
  input  cmd_t      q_cmd,
  output logic      pop,
  hxb_out_if.source out
);

  phase_t           phase, phase_next;
  logic             trim_over, trim_over_next;
  logic [CNT_W-1:0] count, count_next;

  logic             out_valid;
  result_t          out_res;
  logic             pend_valid;
  result_t          pend_res;

  logic             can_load;
  logic [1:0]       n_res;
  result_t          r0, r1, cand;

  // Work out the results of the command at the head of the queue
  always_comb begin
    phase_next     = q_cmd.sos ? PH_RUN : phase;
    trim_over_next = q_cmd.sos ? 1'b0 : trim_over;
    count_next     = q_cmd.sos ? '0 : count;
    n_res          = 2'd0;
    r0             = '0;
    r1             = '0;
    cand           = '0;

    // byte from a held '0'
    if (phase_next == PH_RUN && q_cmd.flush_valid) begin
      if (!(cfg.trim_leading && !trim_over_next && q_cmd.flush_byte == 8'h00)) begin
        trim_over_next = 1'b1;
        cand = '{kind: K_DATA, out_byte: q_cmd.flush_byte, byte_count: '0, last: 1'b0};
        if (n_res == 2'd0) r0 = cand; else r1 = cand;
        n_res      = n_res + 2'd1;
        count_next = count_next + CNT_W'(1);
        if (count_next >= cfg.capacity) phase_next = PH_FULL;
      end
    end

    // decoded byte or error
    if (phase_next == PH_RUN) begin
      if (q_cmd.err) begin
        cand = '{kind: K_ERR, out_byte: 8'h00, byte_count: '0, last: 1'b0};
        if (n_res == 2'd0) r0 = cand; else r1 = cand;
        n_res      = n_res + 2'd1;
        phase_next = PH_ERR;
      end else if (q_cmd.dec_valid) begin
        if (!(cfg.trim_leading && !trim_over_next && q_cmd.dec_byte == 8'h00)) begin
          trim_over_next = 1'b1;
          cand = '{kind: K_DATA, out_byte: q_cmd.dec_byte, byte_count: '0, last: 1'b0};
          if (n_res == 2'd0) r0 = cand; else r1 = cand;
          n_res      = n_res + 2'd1;
          count_next = count_next + CNT_W'(1);
          if (count_next >= cfg.capacity) phase_next = PH_FULL;
        end
      end
    end

    // end of string: empty result padding, then done
    if (q_cmd.eos) begin
      if (phase_next != PH_ERR) begin
        if (count_next == '0 && !cfg.empty_as_null) begin
          cand = '{kind: K_DATA, out_byte: 8'h00, byte_count: '0, last: 1'b0};
          if (n_res == 2'd0) r0 = cand; else r1 = cand;
          n_res      = n_res + 2'd1;
          count_next = CNT_W'(1);
        end
        cand = '{kind: K_DONE, out_byte: 8'h00, byte_count: count_next, last: 1'b0};
        if (n_res == 2'd0) r0 = cand; else r1 = cand;
        n_res = n_res + 2'd1;
      end
      phase_next = PH_AWAIT;
    end

    if (n_res == 2'd2) r1.last = 1'b1;
    else               r0.last = 1'b1;
  end

  // Output handshake
  always_comb begin
    can_load = !out_valid || out.ready;
    pop      = can_load && !pend_valid && q_valid;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_AWAIT;
      trim_over  <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (can_load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_valid) begin
        out_valid  <= (n_res != 2'd0);
        pend_valid <= (n_res == 2'd2);
        phase      <= phase_next;
        trim_over  <= trim_over_next;
        count      <= count_next;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend_valid) begin
        out_res <= pend_res;
      end else if (q_valid) begin
        out_res  <= r0;
        pend_res <= r1;
      end
    end
  end

  assign out.valid      = out_valid;
  assign out.kind       = out_res.kind;
  assign out.out_byte   = out_res.out_byte;
  assign out.byte_count = out_res.byte_count;
  assign out.last       = out_res.last;

endmodule

`default_nettype wire

// ===== rtl/hex_text_to_bytes.sv =====
// Hex text to bytes decoder. Takes one ASCII character per beat, with the
// string length sampled on the first character, and returns data bytes, a
// done beat with the byte count at the NUL, or an error beat on a non-hex
// character. One character is accepted every cycle while the command queue
// is not full; the results of a character pass through the queue and then
// the output register. A character that causes two results holds the output
// register for both, and the four-entry command queue between the character
// front end and the result back end keeps input flowing meanwhile. There is
// no clearing pass after reset. Depends on hxb_pkg, hxb_if, hxb_front,
// hxb_queue and hxb_back.
`default_nettype none

module hex_text_to_bytes
  import hxb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  hxb_in_if.sink                    in,
  hxb_out_if.source                 out
);

  logic             trim_leading;
  logic             empty_as_null;
  logic [CFG_W-1:0] out_capacity;
  cfg_t             cfg;

  logic             push;
  cmd_t             push_cmd;
  logic             q_full;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_leading  <= 1'b1;
      empty_as_null <= 1'b1;
      out_capacity  <= CFG_W'(MAX_OUT);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TRIM:  trim_leading  <= cfg_data[0];
        CFG_EMPTY: empty_as_null <= cfg_data[0];
        CFG_CAP:   out_capacity  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Capacity clamped to the supported range
  always_comb begin
    cfg.trim_leading  = trim_leading;
    cfg.empty_as_null = empty_as_null;
    if (out_capacity == '0)                      cfg.capacity = CNT_W'(1);
    else if (out_capacity > CFG_W'(MAX_OUT))     cfg.capacity = CNT_W'(MAX_OUT);
    else                                         cfg.capacity = out_capacity;
  end

  hxb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in     (in),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  hxb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  hxb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out     (out)
  );

endmodule

`default_nettype wire
